// File: src/mmr_pkg.sv
// ----------------------------------------------------------------------------
// mmr_pkg
// Shared types, codes and constants of the row-at-a-time matrix multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package mmr_pkg;

    // default sizes of the stores
    localparam int DEF_MAX_ROWS  = 64;
    localparam int DEF_MAX_INNER = 64;
    localparam int DEF_MAX_COLS  = 16;

    // widest inner index over the parameter range (up to 1024)
    localparam int KMAXW = 10;

    // field widths
    localparam int ELEM_W = 16;
    localparam int PROD_W = 32;
    localparam int SUM_W  = 40;

    // command codes
    localparam logic [1:0] CMD_WRITE_A = 2'd0;
    localparam logic [1:0] CMD_WRITE_B = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_A_ROWS     = 2'd0;
    localparam logic [1:0] REG_INNER_SIZE = 2'd1;
    localparam logic [1:0] REG_B_COLS     = 2'd2;

    // reset values of the configuration registers
    localparam logic [6:0] RST_A_ROWS     = 7'd64;
    localparam logic [6:0] RST_INNER_SIZE = 7'd64;
    localparam logic [4:0] RST_B_COLS     = 5'd16;

    // input transaction
    typedef struct packed {
        logic [1:0]               command;
        logic [5:0]               row_index;
        logic [5:0]               col_index;
        logic signed [ELEM_W-1:0] element_value;
    } in_t;

    // result transaction
    typedef struct packed {
        logic [5:0]              out_row;
        logic [3:0]              out_col;
        logic signed [SUM_W-1:0] product_value;
        logic                    last;
    } out_t;

    // step handed from cell to cell
    typedef struct packed {
        logic                     valid;
        logic                     first;
        logic                     last;
        logic [KMAXW-1:0]         k;
        logic signed [ELEM_W-1:0] a;
    } chain_t;

    // broadcast write into the column stores of the cells
    typedef struct packed {
        logic              en;
        logic [5:0]        col;
        logic [KMAXW-1:0]  addr;
        logic [ELEM_W-1:0] data;
    } bwr_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_WAIT,
        ST_DRAIN
    } state_t;

endpackage

`default_nettype wire

// File: src/mmr_a_store.sv
// ----------------------------------------------------------------------------
// mmr_a_store
// Store for the elements of A, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mmr_a_store #(
    parameter int DEPTH = mmr_pkg::DEF_MAX_ROWS * mmr_pkg::DEF_MAX_INNER,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                             aclk,
    input  wire logic                             we,
    input  wire logic [AW-1:0]                    waddr,
    input  wire logic [mmr_pkg::ELEM_W-1:0]       wdata,
    input  wire logic [AW-1:0]                    raddr,
    output logic signed [mmr_pkg::ELEM_W-1:0]     rdata
);

    logic [mmr_pkg::ELEM_W-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/mmr_cell.sv
// ----------------------------------------------------------------------------
// mmr_cell
// One column cell: holds a column of B and its accumulator, passes A on.
// ----------------------------------------------------------------------------
`default_nettype none

module mmr_cell #(
    parameter int MAX_INNER = mmr_pkg::DEF_MAX_INNER,
    parameter int COL_INDEX = 0
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire mmr_pkg::chain_t               chain_in,
    output mmr_pkg::chain_t                    chain_out,
    input  wire mmr_pkg::bwr_t                 bwr,
    input  wire logic                          shift_en,
    input  wire logic signed [mmr_pkg::SUM_W-1:0] shift_in,
    output logic signed [mmr_pkg::SUM_W-1:0]   res,
    output logic                               done
);

    localparam int KW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;

    logic [mmr_pkg::ELEM_W-1:0]         bmem [MAX_INNER];
    logic signed [mmr_pkg::ELEM_W-1:0]  b_rd_reg;
    mmr_pkg::chain_t                    chain_d_reg;
    mmr_pkg::chain_t                    chain_p_reg;
    logic signed [mmr_pkg::PROD_W-1:0]  prod_reg;
    logic signed [mmr_pkg::SUM_W-1:0]   acc_reg;
    logic signed [mmr_pkg::SUM_W-1:0]   acc_next;
    logic signed [mmr_pkg::SUM_W-1:0]   res_reg;
    logic                               done_reg;

    // column store of B, read at the step's inner index
    always_ff @(posedge aclk) begin
        if (bwr.en && bwr.col == 6'(COL_INDEX)) begin
            bmem[bwr.addr[KW-1:0]] <= bwr.data;
        end
        b_rd_reg <= bmem[chain_in.k[KW-1:0]];
    end

    // start a new sum on the first step
    always_comb begin
        acc_next = chain_p_reg.first ? mmr_pkg::SUM_W'(prod_reg)
                                     : acc_reg + mmr_pkg::SUM_W'(prod_reg);
    end

    // multiply, accumulate, capture and shift results
    always_ff @(posedge aclk) begin
        prod_reg <= chain_d_reg.a * b_rd_reg;
        if (chain_p_reg.valid) begin
            acc_reg <= acc_next;
        end
        if (chain_p_reg.valid && chain_p_reg.last) begin
            res_reg <= acc_next;
        end else if (shift_en) begin
            res_reg <= shift_in;
        end
        if (!aresetn) begin
            chain_d_reg <= '0;
            chain_p_reg <= '0;
            done_reg    <= 1'b0;
        end else begin
            chain_d_reg <= chain_in;
            chain_p_reg <= chain_d_reg;
            done_reg    <= chain_p_reg.valid && chain_p_reg.last;
        end
    end

    assign chain_out = chain_d_reg;
    assign res       = res_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

// File: src/matrix_multiply_rows.sv
// A compute transaction walks the inner dimension through the cell chain, waits for the
// last cell to finish, then hands out the results one active column at a time, holding
// each result while m_ready is low.
// One item is in work at a time; the inner walk over the A store port sets the pace.
// Reset sets a_rows and inner_size to 64 and b_cols to 16; the stores are not cleared.
// ----------------------------------------------------------------------------
// matrix_multiply_rows
// Row-at-a-time C = A x B in Q8.8 with exact 40-bit sums, one cell per column.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_rows #(
    parameter int MAX_ROWS  = mmr_pkg::DEF_MAX_ROWS,
    parameter int MAX_INNER = mmr_pkg::DEF_MAX_INNER,
    parameter int MAX_COLS  = mmr_pkg::DEF_MAX_COLS
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire mmr_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output mmr_pkg::out_t      m_data,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [6:0]    cfg_data
);

    localparam int ADEPTH = MAX_ROWS * MAX_INNER;
    localparam int AW     = (ADEPTH > 1) ? $clog2(ADEPTH) : 1;
    localparam int KW     = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int JW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    mmr_pkg::state_t state_reg, state_next;
    logic [6:0]      a_rows_reg;
    logic [6:0]      inner_size_reg;
    logic [4:0]      b_cols_reg;
    logic [KW-1:0]   k_reg, k_next;
    logic [JW-1:0]   j_reg, j_next;
    logic [5:0]      row_reg, row_next;
    logic            zero_inner_reg, zero_inner_next;
    mmr_pkg::chain_t feed_reg, feed_next;

    logic [6:0]      nk;
    logic [4:0]      nc;
    logic            row_ok;
    logic            a_we;
    logic [AW-1:0]   a_waddr;
    logic [AW-1:0]   a_raddr;
    logic signed [mmr_pkg::ELEM_W-1:0] a_rdata;
    mmr_pkg::bwr_t   bwr;
    logic            shift_en;
    logic            all_done;
    logic            feed_last;
    logic            out_last;

    mmr_pkg::chain_t                  chain_w [MAX_COLS+1];
    logic signed [mmr_pkg::SUM_W-1:0] res_w   [MAX_COLS+1];
    logic                             done_w  [MAX_COLS];

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_rows_reg     <= mmr_pkg::RST_A_ROWS;
            inner_size_reg <= mmr_pkg::RST_INNER_SIZE;
            b_cols_reg     <= mmr_pkg::RST_B_COLS;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mmr_pkg::REG_A_ROWS:     a_rows_reg     <= cfg_data;
                mmr_pkg::REG_INNER_SIZE: inner_size_reg <= cfg_data;
                mmr_pkg::REG_B_COLS:     b_cols_reg     <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // effective sizes, saturated to the store dimensions
    assign nk = (32'(inner_size_reg) > MAX_INNER) ? 7'(MAX_INNER) : inner_size_reg;
    assign nc = (32'(b_cols_reg) > MAX_COLS) ? 5'(MAX_COLS) : b_cols_reg;
    assign row_ok = (7'(s_data.row_index) < a_rows_reg) && (32'(s_data.row_index) < MAX_ROWS);

    assign feed_last = (32'(k_reg) + 1 == 32'(nk));
    assign out_last  = (32'(j_reg) + 1 == 32'(nc));
    assign all_done  = done_w[MAX_COLS-1];

    // store addresses
    assign a_waddr = AW'(32'(s_data.row_index) * MAX_INNER + 32'(s_data.col_index));
    assign a_raddr = AW'(32'(row_reg) * MAX_INNER + 32'(k_reg));

    // controller next state and outputs
    always_comb begin
        state_next      = state_reg;
        k_next          = k_reg;
        j_next          = j_reg;
        row_next        = row_reg;
        zero_inner_next = zero_inner_reg;
        feed_next       = '0;
        s_ready         = 1'b0;
        m_valid         = 1'b0;
        shift_en        = 1'b0;
        a_we            = 1'b0;
        bwr.en          = 1'b0;
        bwr.col         = s_data.col_index;
        bwr.addr        = mmr_pkg::KMAXW'(s_data.row_index);
        bwr.data        = s_data.element_value;

        unique case (state_reg)
            mmr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (s_data.command)
                        mmr_pkg::CMD_WRITE_A: begin
                            a_we = row_ok && (7'(s_data.col_index) < nk);
                        end
                        mmr_pkg::CMD_WRITE_B: begin
                            bwr.en = (7'(s_data.row_index) < nk)
                                  && (7'(s_data.col_index) < 7'(nc));
                        end
                        mmr_pkg::CMD_COMPUTE: begin
                            if (row_ok && nc != 5'd0) begin
                                row_next = s_data.row_index;
                                k_next   = '0;
                                j_next   = '0;
                                if (nk == 7'd0) begin
                                    zero_inner_next = 1'b1;
                                    state_next      = mmr_pkg::ST_DRAIN;
                                end else begin
                                    zero_inner_next = 1'b0;
                                    state_next      = mmr_pkg::ST_FEED;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            mmr_pkg::ST_FEED: begin
                feed_next.valid = 1'b1;
                feed_next.first = (k_reg == '0);
                feed_next.last  = feed_last;
                feed_next.k     = mmr_pkg::KMAXW'(k_reg);
                k_next          = k_reg + 1'b1;
                if (feed_last) begin
                    state_next = mmr_pkg::ST_WAIT;
                end
            end
            mmr_pkg::ST_WAIT: begin
                if (all_done) begin
                    state_next = mmr_pkg::ST_DRAIN;
                end
            end
            mmr_pkg::ST_DRAIN: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    shift_en = 1'b1;
                    j_next   = j_reg + 1'b1;
                    if (out_last) begin
                        state_next = mmr_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = mmr_pkg::ST_IDLE;
        endcase
    end

    // controller registers
    always_ff @(posedge aclk) begin
        k_reg          <= k_next;
        j_reg          <= j_next;
        row_reg        <= row_next;
        zero_inner_reg <= zero_inner_next;
        if (!aresetn) begin
            state_reg <= mmr_pkg::ST_IDLE;
            feed_reg  <= '0;
        end else begin
            state_reg <= state_next;
            feed_reg  <= feed_next;
        end
    end

    // A store
    mmr_a_store #(
        .DEPTH (ADEPTH),
        .AW    (AW)
    ) u_a_store (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (s_data.element_value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    // first step of the chain carries the A element just read
    always_comb begin
        chain_w[0]   = feed_reg;
        chain_w[0].a = a_rdata;
    end

    assign res_w[MAX_COLS] = '0;

    // row of column cells
    for (genvar g = 0; g < MAX_COLS; g++) begin : g_cell
        mmr_cell #(
            .MAX_INNER (MAX_INNER),
            .COL_INDEX (g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .chain_in  (chain_w[g]),
            .chain_out (chain_w[g+1]),
            .bwr       (bwr),
            .shift_en  (shift_en),
            .shift_in  (res_w[g+1]),
            .res       (res_w[g]),
            .done      (done_w[g])
        );
    end

    // result transaction
    always_comb begin
        m_data.out_row       = row_reg;
        m_data.out_col       = 4'(j_reg);
        m_data.product_value = zero_inner_reg ? '0 : res_w[0];
        m_data.last          = out_last;
    end

    // one item at a time: no intake while results are pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while results pending");

    // the final column closes the row
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last) |=> !m_valid)
        else $error("results continue after last column");

    // columns stay inside the active width
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_data.out_col) < 32'(nc)))
        else $error("result column outside active columns");

    // the chain finishes only while the controller waits for it
    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        all_done |-> (state_reg == mmr_pkg::ST_WAIT))
        else $error("chain finished outside wait state");

endmodule

`default_nettype wire
